FILE: rtl/core/lfu_pkg.sv
// Shared constants, codes and controller/datapath command types for the
// LFU aging replacement table. Depends on nothing; every other file imports it.
package lfu_pkg;

	localparam int ENTRIES  = 32;
	localparam int KEY_BITS = 32;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [1:0] FUNC_UPDATE = 2'd0;
	localparam logic [1:0] FUNC_EVICT  = 2'd1;
	localparam logic [1:0] FUNC_DELETE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_stat_t;

endpackage

FILE: rtl/core/lfu_ctrl.sv
// Controller for the LFU aging replacement table: idle, table scan, commit.
// Depends on lfu_pkg for the command and status structs.
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lfu_pkg::dp_stat_t stat,
	output lfu_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import lfu_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   scan_q;
	logic   commit_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			busy_q   <= 1'b0;
			scan_q   <= 1'b0;
			commit_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			commit_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						busy_q  <= 1'b1;
						scan_q  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						state_q  <= S_COMMIT;
						scan_q   <= 1'b0;
						commit_q <= 1'b1;
					end
				end
				S_COMMIT: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					scan_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.load   = start && !busy_q && (state_q == S_IDLE);
	assign cmd.scan   = scan_q;
	assign cmd.commit = commit_q;
	assign busy       = busy_q;
	assign done       = done_q;

endmodule

FILE: rtl/core/lfu_datapath.sv
// Datapath: key and priority memories, valid and rank registers, scan trackers,
// commit logic, age register and result registers. Depends on lfu_pkg.
module lfu_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfu_pkg::dp_cmd_t            cmd,
	output lfu_pkg::dp_stat_t           stat,
	input  logic [1:0]                  func,
	input  logic [31:0]                 key_in,
	input  logic [31:0]                 access_freq,
	output logic [1:0]                  status,
	output logic [31:0]                 victim_key,
	output logic [31:0]                 victim_priority
);
	import lfu_pkg::*;

	typedef enum logic [1:0] {
		RK_NONE,
		RK_PROMOTE,
		RK_INSERT,
		RK_REMOVE
	} rank_op_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// latched operation
	logic [1:0]          func_q;
	logic [KEY_BITS-1:0] key_q;
	logic [DATA_W-1:0]   prio_q;
	logic [DATA_W-1:0]   age_q;

	// table storage
	logic [KEY_BITS-1:0] key_mem  [ENTRIES];
	logic [DATA_W-1:0]   prio_mem [ENTRIES];
	logic [KEY_BITS-1:0] key_rd_s1;
	logic [DATA_W-1:0]   prio_rd_s1;
	logic [ENTRIES-1:0]  valid_q;
	logic [IDX_W-1:0]    rank_q [ENTRIES];

	// scan sequencing
	logic [IDX_W-1:0] idx_q;
	logic             iss_q;
	logic             rd_v_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	// scan trackers
	logic                any_q;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [DATA_W-1:0]   hit_prio_q;
	logic [IDX_W-1:0]    hit_rank_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                best_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [DATA_W-1:0]   best_prio_q;
	logic [IDX_W-1:0]    best_rank_q;
	logic [KEY_BITS-1:0] best_key_q;

	// commit decisions
	logic [1:0]        st_c;
	logic [DATA_W-1:0] vkey_c;
	logic [DATA_W-1:0] vprio_c;
	logic              key_we;
	logic              prio_we;
	logic [IDX_W-1:0]  wr_idx;
	logic              set_valid;
	logic              clr_valid;
	rank_op_t          rank_op;
	logic [IDX_W-1:0]  rank_slot;
	logic [IDX_W-1:0]  rank_ref;
	logic              age_we;

	// result registers
	logic [1:0]        status_q;
	logic [DATA_W-1:0] vkey_q;
	logic [DATA_W-1:0] vprio_q;

	logic              cur_v;
	logic [IDX_W-1:0]  cur_rank;

	// latch the operation and form the aged priority
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			key_q  <= key_in[KEY_BITS-1:0];
			prio_q <= access_freq + age_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_we) begin
			age_q <= best_prio_q;
		end
	end

	// memories: one write port, one registered read port at the scan index
	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[wr_idx] <= key_q;
		key_rd_s1 <= key_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (prio_we)
			prio_mem[wr_idx] <= prio_q;
		prio_rd_s1 <= prio_mem[idx_q];
	end

	// scan address sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			iss_q      <= 1'b0;
			rd_v_s1    <= 1'b0;
			rd_last_s1 <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			rd_v_s1    <= 1'b0;
			rd_last_s1 <= 1'b0;
			if (cmd.load) begin
				idx_q <= '0;
				iss_q <= 1'b1;
			end else if (cmd.scan && iss_q) begin
				rd_v_s1    <= 1'b1;
				rd_idx_s1  <= idx_q;
				rd_last_s1 <= (idx_q == LAST_IDX);
				if (idx_q == LAST_IDX)
					iss_q <= 1'b0;
				else
					idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign stat.scan_done = rd_v_s1 && rd_last_s1;

	assign cur_v    = valid_q[rd_idx_s1];
	assign cur_rank = rank_q[rd_idx_s1];

	// fold each entry into the match, free and eviction trackers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			any_q  <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			best_q <= 1'b0;
		end else if (rd_v_s1) begin
			if (cur_v)
				any_q <= 1'b1;
			if (cur_v && !hit_q && key_rd_s1 == key_q) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= rd_idx_s1;
				hit_prio_q <= prio_rd_s1;
				hit_rank_q <= cur_rank;
			end
			if (!cur_v && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (cur_v && (!best_q || prio_rd_s1 < best_prio_q ||
					(prio_rd_s1 == best_prio_q && cur_rank > best_rank_q))) begin
				best_q      <= 1'b1;
				best_idx_q  <= rd_idx_s1;
				best_prio_q <= prio_rd_s1;
				best_rank_q <= cur_rank;
				best_key_q  <= key_rd_s1;
			end
		end
	end

	// commit decision
	always_comb begin
		st_c      = ST_OK;
		vkey_c    = '0;
		vprio_c   = '0;
		key_we    = 1'b0;
		prio_we   = 1'b0;
		wr_idx    = hit_idx_q;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		rank_op   = RK_NONE;
		rank_slot = hit_idx_q;
		rank_ref  = hit_rank_q;
		age_we    = 1'b0;
		if (cmd.commit) begin
			unique case (func_q)
				FUNC_UPDATE: begin
					if (hit_q) begin
						if (hit_prio_q != prio_q) begin
							prio_we = 1'b1;
							rank_op = RK_PROMOTE;
						end
					end else if (free_q) begin
						wr_idx    = free_idx_q;
						key_we    = 1'b1;
						prio_we   = 1'b1;
						set_valid = 1'b1;
						rank_op   = RK_INSERT;
						rank_slot = free_idx_q;
					end else begin
						st_c = ST_FULL;
					end
				end
				FUNC_EVICT: begin
					if (best_q) begin
						vkey_c    = DATA_W'(best_key_q);
						vprio_c   = best_prio_q;
						age_we    = 1'b1;
						clr_valid = 1'b1;
						rank_op   = RK_REMOVE;
						rank_slot = best_idx_q;
						rank_ref  = best_rank_q;
					end else begin
						st_c = ST_EMPTY;
					end
				end
				FUNC_DELETE: begin
					if (!any_q) begin
						st_c = ST_EMPTY;
					end else if (hit_q) begin
						clr_valid = 1'b1;
						rank_op   = RK_REMOVE;
					end else begin
						st_c = ST_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (set_valid)
				valid_q[wr_idx] <= 1'b1;
			if (clr_valid)
				valid_q[rank_slot] <= 1'b0;
		end
	end

	// recency ranks: every entry updates in parallel against the commit slot
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			case (rank_op)
				RK_PROMOTE: begin
					if (IDX_W'(i) == rank_slot)
						rank_q[i] <= '0;
					else if (valid_q[i] && rank_q[i] < rank_ref)
						rank_q[i] <= rank_q[i] + 1'b1;
				end
				RK_INSERT: begin
					if (IDX_W'(i) == rank_slot)
						rank_q[i] <= '0;
					else if (valid_q[i])
						rank_q[i] <= rank_q[i] + 1'b1;
				end
				RK_REMOVE: begin
					if (valid_q[i] && rank_q[i] > rank_ref)
						rank_q[i] <= rank_q[i] - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= st_c;
			vkey_q   <= vkey_c;
			vprio_q  <= vprio_c;
		end
	end

	assign status          = status_q;
	assign victim_key      = vkey_q;
	assign victim_priority = vprio_q;

endmodule

FILE: rtl/core/lfu_aging_replacement_table.sv
// Top level of the LFU aging replacement table: controller plus datapath.
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath.
//
// Usage:
//   Command channel: drive func, key_in and access_freq with start high. The
//   command transfers at the rising edge where start is high and busy is low.
//   busy stays high from the cycle after that transfer until the result is out.
//   Result channel: done is high for exactly one cycle, with status,
//   victim_key and victim_priority valid in that cycle. The receiver cannot
//   stall; the result transfers at the edge that ends the done cycle.
//   Sequencing: the next command may transfer at the edge that ends the done
//   cycle, so the block takes no new command while one is in flight. The
//   scan sets the pace: the memories have one registered read port, so one
//   entry per cycle, then a registered read, then a commit state that
//   writes the chosen slot, the recency ranks and the age register.
//   Reset: arst_n low clears all entries to invalid, age to zero and drops busy
//   and done. No clearing pass is needed; valid bits gate every memory read.
module lfu_aging_replacement_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] key_in,
	input  logic [31:0] access_freq,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] victim_key,
	output logic [31:0] victim_priority
);
	import lfu_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequence load, scan and commit
	lfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// hold the table, scan it and apply the operation
	lfu_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.func            (func),
		.key_in          (key_in),
		.access_freq     (access_freq),
		.status          (status),
		.victim_key      (victim_key),
		.victim_priority (victim_priority)
	);

	// the result cycle never overlaps an operation in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a transferred command always marks the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not raise busy");

	// one result per command: the strobe drops after each result
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// failed operations report no victim
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (victim_key == '0 && victim_priority == '0))
		else $error("victim fields set on a failed operation");

endmodule

FILE: verif/lfu_table_checker.sv
`timescale 1ns / 1ps
// Checker for the LFU aging replacement table: watches the command and result
// channels, predicts every result from its own copy of the table, and compares.
// Depends on lfu_pkg for sizes, operation codes and status codes.
module lfu_table_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        func,
	input  logic [31:0]       key_in,
	input  logic [31:0]       access_freq,
	input  logic              done,
	input  logic [1:0]        status,
	input  logic [31:0]       victim_key,
	input  logic [31:0]       victim_priority,
	output int                fail_count,
	output int                pending_count,
	output int                result_count,
	output logic [3:0][31:0]  status_count
);
	import lfu_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] vkey;
		logic [31:0] vprio;
	} table_result_t;

	localparam int REPORT_CAP = 100;

	logic              slot_valid [ENTRIES];
	logic [31:0]       slot_key   [ENTRIES];
	logic [31:0]       slot_prio  [ENTRIES];
	logic [IDX_W-1:0]  slot_rank  [ENTRIES];
	logic [31:0]       age_q;

	table_result_t     owed_results [$];
	int                mismatches;
	int                results_in;
	logic [3:0][31:0]  status_tally;

	function automatic int find_slot(input logic [31:0] key);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && slot_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < ENTRIES; i++)
			if (!slot_valid[i])
				return i;
		return -1;
	endfunction

	function automatic int find_slot_any();
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i])
				return i;
		return -1;
	endfunction

	// move a slot to rank 0; a fresh insert pushes every other entry back
	task automatic promote(input int slot, input bit was_valid);
		logic [IDX_W-1:0] old;
		old = slot_rank[slot];
		for (int i = 0; i < ENTRIES; i++)
			if (i != slot && slot_valid[i] && (!was_valid || slot_rank[i] < old))
				slot_rank[i] = slot_rank[i] + 1'b1;
		slot_rank[slot] = '0;
	endtask

	task automatic drop_slot(input int slot);
		logic [IDX_W-1:0] r;
		r = slot_rank[slot];
		slot_valid[slot] = 1'b0;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && slot_rank[i] > r)
				slot_rank[i] = slot_rank[i] - 1'b1;
	endtask

	task automatic apply_command(input logic [1:0] op, input logic [31:0] key,
			input logic [31:0] freq, output table_result_t res);
		int          slot;
		logic [31:0] prio;
		res = '0;
		res.status = ST_OK;
		case (op)
			FUNC_UPDATE: begin
				prio = freq + age_q;
				slot = find_slot(key);
				if (slot >= 0) begin
					// an unchanged priority keeps the entry's recency
					if (slot_prio[slot] != prio) begin
						slot_prio[slot] = prio;
						promote(slot, 1'b1);
					end
				end else begin
					slot = free_slot();
					if (slot < 0) begin
						res.status = ST_FULL;
					end else begin
						slot_valid[slot] = 1'b1;
						slot_key[slot] = key;
						slot_prio[slot] = prio;
						promote(slot, 1'b0);
					end
				end
			end
			FUNC_EVICT: begin
				// lowest priority wins; on a tie the least recently placed
				slot = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (slot_valid[i] && (slot < 0 || slot_prio[i] < slot_prio[slot] ||
							(slot_prio[i] == slot_prio[slot] &&
							 slot_rank[i] > slot_rank[slot])))
						slot = i;
				if (slot < 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.vkey = slot_key[slot];
					res.vprio = slot_prio[slot];
					age_q = slot_prio[slot];
					drop_slot(slot);
				end
			end
			FUNC_DELETE: begin
				slot = find_slot(key);
				if (free_slot() == 0 && find_slot_any() < 0)
					res.status = ST_EMPTY;
				else if (slot < 0)
					res.status = ST_NOT_FOUND;
				else
					drop_slot(slot);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		table_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_valid[i] = 1'b0;
				slot_key[i] = '0;
				slot_prio[i] = '0;
				slot_rank[i] = '0;
			end
			age_q = '0;
			owed_results.delete();
			mismatches = 0;
			results_in = 0;
			status_tally = '0;
		end else begin
			// check the result first: a new command may transfer on the done edge
			if (done) begin
				got = '{status, victim_key, victim_priority};
				results_in++;
				status_tally[status] = status_tally[status] + 32'd1;
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: result with none expected: status %0d key %h prio %h",
							$realtime, got.status, got.vkey, got.vprio);
				end else begin
					want = owed_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_CAP)
							$display("%0t: expected status %0d key %h prio %h, got status %0d key %h prio %h",
								$realtime, want.status, want.vkey, want.vprio,
								got.status, got.vkey, got.vprio);
					end
				end
			end
			if (start && !busy) begin
				apply_command(func, key_in, access_freq, want);
				owed_results.push_back(want);
			end
		end
		// publish with nonblocking updates so readers see a settled value
		fail_count <= mismatches;
		pending_count <= owed_results.size();
		result_count <= results_in;
		status_count <= status_tally;
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Top of the LFU aging replacement table testbench: clock, reset, command
// stimulus and verdict. Depends on lfu_pkg, the table RTL and lfu_table_checker.
module tb;
	import lfu_pkg::*;

	// func 3 has no operation behind it; the block answers ok with zero fields
	localparam logic [1:0] FUNC_RESERVED = 2'd3;
	localparam int POOL_SIZE   = 40;
	localparam int TARGET_CMDS = 1120;
	// Sized from the slowest correct command (the longest idle gap plus a table
	// scan and a margin), several times over the whole run.
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [31:0] key_in;
	logic [31:0] access_freq;
	logic        done;
	logic [1:0]  status;
	logic [31:0] victim_key;
	logic [31:0] victim_priority;

	int               fail_count;
	int               pending_count;
	int               result_count;
	logic [3:0][31:0] status_count;

	int          cycle_count;
	int          issued;
	bit          steady;
	logic [31:0] key_pool [POOL_SIZE];
	logic [31:0] last_freq;

	lfu_aging_replacement_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.key_in          (key_in),
		.access_freq     (access_freq),
		.done            (done),
		.status          (status),
		.victim_key      (victim_key),
		.victim_priority (victim_priority)
	);

	lfu_table_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.key_in          (key_in),
		.access_freq     (access_freq),
		.done            (done),
		.status          (status),
		.victim_key      (victim_key),
		.victim_priority (victim_priority),
		.fail_count      (fail_count),
		.pending_count   (pending_count),
		.result_count    (result_count),
		.status_count    (status_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog: end the run if the block stops answering
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lfu_aging_replacement_table test failed");
			$finish;
		end
	end

	// Present one command and hold it until it transfers. Idle first for a
	// drawn number of cycles, unless this stretch runs back to back.
	task automatic issue_command(input logic [1:0] op, input logic [31:0] key,
			input logic [31:0] freq);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= op;
		key_in <= key;
		access_freq <= freq;
		@(posedge clk);
		while (busy) @(posedge clk);
		issued++;
	endtask

	// Drop start and hold off until every owed result has come back.
	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// Small values make priority ties common; values near the top force the
	// age addition to wrap; a repeated value on a known key leaves it unchanged.
	function automatic logic [31:0] pick_freq();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			last_freq = $urandom_range(0, 6);
		else if (r < 65)
			last_freq = $urandom;
		else if (r < 80)
			last_freq = 32'hFFFF_FFFF - $urandom_range(0, 20);
		return last_freq;
	endfunction

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return key_pool[$urandom_range(0, 7)];
		else if (r < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	initial begin
		int kind;
		int base;
		int n;
		int r;

		arst_n = 1'b0;
		start <= 1'b0;
		func <= FUNC_UPDATE;
		key_in <= '0;
		access_freq <= '0;
		issued = 0;
		steady = 1'b0;
		last_freq = '0;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty table, reserved func, field extremes, unchanged
		// priority, tie on priority, wrap of the priority sum, unknown key
		issue_command(FUNC_EVICT, 32'h0, 32'h0);
		issue_command(FUNC_DELETE, 32'h0, 32'h0);
		issue_command(FUNC_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_command(FUNC_UPDATE, 32'h0, 32'h0);
		issue_command(FUNC_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_command(FUNC_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_command(FUNC_DELETE, 32'h5, 32'h0);
		issue_command(FUNC_EVICT, 32'hFFFF_FFFF, 32'h0);
		issue_command(FUNC_UPDATE, 32'h1234_5678, 32'd10);
		issue_command(FUNC_UPDATE, 32'hA5A5_A5A5, 32'd10);
		issue_command(FUNC_UPDATE, 32'h5A5A_5A5A, 32'd10);
		issue_command(FUNC_UPDATE, 32'h1234_5678, 32'd10);
		issue_command(FUNC_EVICT, 32'h0, 32'h0);
		issue_command(FUNC_UPDATE, 32'h5A5A_5A5A, 32'd20);
		issue_command(FUNC_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFF8);
		issue_command(FUNC_EVICT, 32'h0, 32'h0);
		issue_command(FUNC_DELETE, 32'hA5A5_A5A5, 32'h0);
		issue_command(FUNC_DELETE, 32'hA5A5_A5A5, 32'h0);
		issue_command(FUNC_EVICT, 32'h0, 32'h0);
		issue_command(FUNC_EVICT, 32'h0, 32'h0);
		issue_command(FUNC_RESERVED, 32'h0, 32'h0);
		wait_for_results();

		// random rounds: fill bursts drive the table to full, drain bursts
		// empty it again, mixed rounds stir everything in between
		while (issued < TARGET_CMDS) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0)
				wait_for_results();
			kind = $urandom_range(0, 5);
			if (kind < 2) begin
				base = $urandom_range(0, 7);
				for (int i = 0; i < 36; i++)
					issue_command(FUNC_UPDATE, key_pool[(base + i) % POOL_SIZE], pick_freq());
			end else if (kind == 2) begin
				n = $urandom_range(10, 40);
				for (int i = 0; i < n; i++) begin
					r = $urandom_range(0, 99);
					if (r < 60)
						issue_command(FUNC_EVICT, $urandom, $urandom);
					else if (r < 95)
						issue_command(FUNC_DELETE, key_pool[$urandom_range(0, POOL_SIZE - 1)],
							$urandom);
					else
						issue_command(FUNC_DELETE, $urandom, $urandom);
				end
			end else begin
				for (int i = 0; i < 40; i++) begin
					r = $urandom_range(0, 99);
					if (r < 50)
						issue_command(FUNC_UPDATE, pick_key(), pick_freq());
					else if (r < 70)
						issue_command(FUNC_EVICT, $urandom, $urandom);
					else if (r < 92)
						issue_command(FUNC_DELETE, pick_key(), $urandom);
					else
						issue_command(FUNC_RESERVED, $urandom, $urandom);
				end
			end
		end

		// drain the result channel, then settle for one more command's latency
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d commands and %0d checked results over %0d cycles.",
			issued, result_count, cycle_count);
		$display("Result status mix: ok %0d, not found %0d, empty %0d, full %0d.",
			status_count[ST_OK], status_count[ST_NOT_FOUND],
			status_count[ST_EMPTY], status_count[ST_FULL]);
		if (fail_count == 0 && pending_count == 0)
			$display("lfu_aging_replacement_table test passed");
		else
			$display("lfu_aging_replacement_table test failed");
		$finish;
	end

endmodule
